### sv/msch_pkg.sv
`default_nettype none

package msch_pkg;

    // Field and register widths.
    localparam int CFG_W      = 20;
    localparam int TIME_W     = 21;
    localparam int IDX_W      = 3;
    localparam int COUNT_BITS = 16;

    // The divider takes up to four times the cycle time, padded to an even width
    // so that it retires two quotient bits per cycle.
    localparam int DVD_W    = 24;
    localparam int DIV_ITER = DVD_W / 2;
    localparam int ITER_W   = $clog2(DIV_ITER);

    // Compare width wide enough for both a quotient and a stored counter.
    localparam int CMP_W = ((DVD_W > COUNT_BITS) ? DVD_W : COUNT_BITS) + 1;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_SIM_PERIOD,
        REG_RECV_PERIOD,
        REG_SENSE_PERIOD,
        REG_SEND_PERIOD,
        REG_COACH_PERIOD,
        REG_SYNCH_OFFSET,
        REG_COMMON_PERIOD
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] sim_period;
        logic [CFG_W-1:0] recv_period;
        logic [CFG_W-1:0] sense_period;
        logic [CFG_W-1:0] send_period;
        logic [CFG_W-1:0] coach_period;
        logic [CFG_W-1:0] synch_offset;
        logic [CFG_W-1:0] common_period;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [CFG_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [CFG_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

### sv/msch_regs.sv
`default_nettype none

module msch_regs (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire  [msch_pkg::IDX_W-1:0]    cfg_index,
    input  wire  [msch_pkg::CFG_W-1:0]    cfg_data,
    output msch_pkg::cfg_t                cfg
);
    import msch_pkg::*;

    logic [CFG_W-1:0] sim_reg;
    logic [CFG_W-1:0] recv_reg;
    logic [CFG_W-1:0] sense_reg;
    logic [CFG_W-1:0] send_reg;
    logic [CFG_W-1:0] coach_reg;
    logic [CFG_W-1:0] synch_reg;
    logic [CFG_W-1:0] common_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sim_reg    <= CFG_W'(100000);
            recv_reg   <= CFG_W'(10000);
            sense_reg  <= CFG_W'(100000);
            send_reg   <= CFG_W'(150000);
            coach_reg  <= CFG_W'(100000);
            synch_reg  <= CFG_W'(30000);
            common_reg <= CFG_W'(300000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIM_PERIOD:    sim_reg    <= cfg_data;
                REG_RECV_PERIOD:   recv_reg   <= cfg_data;
                REG_SENSE_PERIOD:  sense_reg  <= cfg_data;
                REG_SEND_PERIOD:   send_reg   <= cfg_data;
                REG_COACH_PERIOD:  coach_reg  <= cfg_data;
                REG_SYNCH_OFFSET:  synch_reg  <= cfg_data;
                REG_COMMON_PERIOD: common_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // A period of zero is treated as one microsecond.
    function automatic logic [CFG_W-1:0] nonzero(input logic [CFG_W-1:0] p);
        begin
            nonzero = (p == '0) ? CFG_W'(1) : p;
        end
    endfunction

    always_comb
    begin
        cfg.sim_period    = nonzero(sim_reg);
        cfg.recv_period   = nonzero(recv_reg);
        cfg.sense_period  = nonzero(sense_reg);
        cfg.send_period   = nonzero(send_reg);
        cfg.coach_period  = nonzero(coach_reg);
        cfg.synch_offset  = synch_reg;
        cfg.common_period = common_reg;
    end

endmodule

`default_nettype wire

### sv/msch_div.sv
`default_nettype none

module msch_div (
    input  wire                  clk,
    input  wire                  rst_n,
    input  msch_pkg::div_req_t   req,
    output msch_pkg::div_rsp_t   rsp
);
    import msch_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  dsr_reg;

    logic [DVD_W-1:0]  dvd_next;
    logic [CFG_W-1:0]  rem_next;
    logic [CFG_W:0]    step_hi;
    logic [CFG_W:0]    step_lo;

    // One restoring step: shift in a dividend bit and subtract when it fits.
    // The partial remainder stays below the divisor, so it never needs more bits.
    function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] r,
                                                 input logic             b,
                                                 input logic [CFG_W-1:0] d);
        logic [CFG_W:0] s;
        logic [CFG_W:0] diff;
        begin
            s    = {r, b};
            diff = s - {1'b0, d};
            if (s >= {1'b0, d})
                div_step = {1'b1, diff[CFG_W-1:0]};
            else
                div_step = {1'b0, s[CFG_W-1:0]};
        end
    endfunction

    always_comb
    begin
        step_hi  = div_step(rem_reg, dvd_reg[DVD_W-1], dsr_reg);
        step_lo  = div_step(step_hi[CFG_W-1:0], dvd_reg[DVD_W-2], dsr_reg);
        rem_next = step_lo[CFG_W-1:0];
        dvd_next = {dvd_reg[DVD_W-3:0], step_hi[CFG_W], step_lo[CFG_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= CFG_W'(1);
        end
        else if (req.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= ITER_W'(DIV_ITER - 1);
            dvd_reg  <= req.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### sv/multirate_event_scheduler.sv
// A tick word is taken only in idle, and no new tick is accepted until its flags word is
// loaded. Eleven divisions run in turn on one shared divider that retires two quotient
// bits per cycle while a division is busy.
// The flags register frees the next tick while a finished word waits downstream.
// Reset (asynchronous, active low) loads the default periods, clears the cycle time
// and the synch flag, and sets every occurrence counter to one.
`default_nettype none

module multirate_event_scheduler (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire  [msch_pkg::IDX_W-1:0]  cfg_index,
    input  wire  [msch_pkg::CFG_W-1:0]  cfg_data,
    input  wire                         tick_valid,
    output logic                        tick_ready,
    input  wire  [msch_pkg::CFG_W-1:0]  advance_us,
    output logic                        flags_valid,
    input  wire                         flags_ready,
    output logic                        fire_recv,
    output logic                        fire_sim,
    output logic                        fire_sense,
    output logic                        fire_visual,
    output logic                        fire_synch,
    output logic                        fire_coach
);
    import msch_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_SIM_T,
        OP_SIM_Q,
        OP_RECV_T,
        OP_RECV_Q,
        OP_SENSE_T,
        OP_SENSE_Q,
        OP_VIS_T,
        OP_VIS_Q,
        OP_SYNCH,
        OP_COACH_T,
        OP_COACH_Q
    } op_t;

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    state_t           state_reg;
    op_t              op_reg;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] cycle_time_reg;
    logic [CMP_W-1:0]  c_reg;

    logic [COUNT_BITS-1:0] sim_count_reg;
    logic [COUNT_BITS-1:0] recv_count_reg;
    logic [COUNT_BITS-1:0] sense_count_reg;
    logic [COUNT_BITS-1:0] visual_count_reg;
    logic [COUNT_BITS-1:0] coach_count_reg;
    logic [COUNT_BITS-1:0] synch_count_reg;
    logic                  synch_done_reg;

    logic f_recv_reg, f_sim_reg, f_sense_reg, f_vis_reg, f_synch_reg, f_coach_reg;
    logic fire_recv_reg, fire_sim_reg, fire_sense_reg;
    logic fire_visual_reg, fire_synch_reg, fire_coach_reg;
    logic flags_valid_reg;

    logic [CMP_W-1:0]      quo_w;
    logic                  syn_ge;
    logic [TIME_W-1:0]     syn_diff;
    logic [COUNT_BITS-1:0] synch_prev;
    logic                  finish_load;

    msch_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // The counter catches up to quotient plus one, or returns to one at the wrap.
    function automatic logic [COUNT_BITS-1:0] next_count(input logic [CMP_W-1:0] q,
                                                         input logic [CMP_W-1:0] c);
        logic [CMP_W-1:0] sum;
        begin
            sum = c + CMP_W'(1);
            if (q <= c)
                next_count = COUNT_BITS'(1);
            else
                next_count = sum[COUNT_BITS-1:0];
        end
    endfunction

    assign quo_w       = CMP_W'(div_rsp.quotient);
    assign syn_ge      = (t_reg >= TIME_W'(cfg.synch_offset));
    assign syn_diff    = t_reg - TIME_W'(cfg.synch_offset);
    // The step index before the synch counter wraps at the counter width.
    assign synch_prev  = synch_count_reg - COUNT_BITS'(1);
    assign finish_load = (state_reg == S_FINISH) && (!flags_valid_reg || flags_ready);

    // Comparing the time against period times counter is the same as comparing
    // the floor quotient against the counter, so the divider covers every test.
    always_comb
    begin
        div_req.start    = (state_reg == S_START);
        div_req.dividend = DVD_W'(t_reg);
        div_req.divisor  = cfg.sim_period;
        case (op_reg)
            OP_SIM_T:
            begin
                div_req.dividend = DVD_W'(t_reg);
                div_req.divisor  = cfg.sim_period;
            end
            OP_SIM_Q:
            begin
                div_req.dividend = DVD_W'(cfg.common_period);
                div_req.divisor  = cfg.sim_period;
            end
            OP_RECV_T:
            begin
                div_req.dividend = DVD_W'(t_reg);
                div_req.divisor  = cfg.recv_period;
            end
            OP_RECV_Q:
            begin
                div_req.dividend = DVD_W'(cfg.common_period);
                div_req.divisor  = cfg.recv_period;
            end
            OP_SENSE_T:
            begin
                div_req.dividend = DVD_W'(t_reg);
                div_req.divisor  = cfg.sense_period;
            end
            OP_SENSE_Q:
            begin
                div_req.dividend = DVD_W'(cfg.common_period);
                div_req.divisor  = cfg.sense_period;
            end
            OP_VIS_T:
            begin
                div_req.dividend = DVD_W'({t_reg, 2'b00});
                div_req.divisor  = cfg.send_period;
            end
            OP_VIS_Q:
            begin
                div_req.dividend = DVD_W'(cfg.common_period);
                div_req.divisor  = cfg.send_period;
            end
            OP_SYNCH:
            begin
                div_req.dividend = syn_ge ? DVD_W'(syn_diff) : '0;
                div_req.divisor  = cfg.sim_period;
            end
            OP_COACH_T:
            begin
                div_req.dividend = DVD_W'(t_reg);
                div_req.divisor  = cfg.coach_period;
            end
            OP_COACH_Q:
            begin
                div_req.dividend = DVD_W'(cfg.common_period);
                div_req.divisor  = cfg.coach_period;
            end
            default:
            begin
                div_req.dividend = DVD_W'(t_reg);
                div_req.divisor  = cfg.sim_period;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_SIM_T;
            t_reg            <= '0;
            cycle_time_reg   <= '0;
            c_reg            <= '0;
            sim_count_reg    <= COUNT_BITS'(1);
            recv_count_reg   <= COUNT_BITS'(1);
            sense_count_reg  <= COUNT_BITS'(1);
            visual_count_reg <= COUNT_BITS'(1);
            coach_count_reg  <= COUNT_BITS'(1);
            synch_count_reg  <= COUNT_BITS'(1);
            synch_done_reg   <= 1'b0;
            f_recv_reg       <= 1'b0;
            f_sim_reg        <= 1'b0;
            f_sense_reg      <= 1'b0;
            f_vis_reg        <= 1'b0;
            f_synch_reg      <= 1'b0;
            f_coach_reg      <= 1'b0;
            fire_recv_reg    <= 1'b0;
            fire_sim_reg     <= 1'b0;
            fire_sense_reg   <= 1'b0;
            fire_visual_reg  <= 1'b0;
            fire_synch_reg   <= 1'b0;
            fire_coach_reg   <= 1'b0;
            flags_valid_reg  <= 1'b0;
        end
        else
        begin
            if (finish_load)
                flags_valid_reg <= 1'b1;
            else if (flags_valid_reg && flags_ready)
                flags_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (tick_valid)
                    begin
                        t_reg       <= cycle_time_reg + TIME_W'(advance_us);
                        op_reg      <= OP_SIM_T;
                        f_recv_reg  <= 1'b0;
                        f_sim_reg   <= 1'b0;
                        f_sense_reg <= 1'b0;
                        f_vis_reg   <= 1'b0;
                        f_synch_reg <= 1'b0;
                        f_coach_reg <= 1'b0;
                        state_reg   <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_START;
                        case (op_reg)
                            OP_SIM_T:
                            begin
                                // A late step snaps the time down to its boundary.
                                if (quo_w >= CMP_W'(sim_count_reg))
                                begin
                                    f_sim_reg <= 1'b1;
                                    t_reg     <= t_reg - TIME_W'(div_rsp.remainder);
                                    c_reg     <= quo_w;
                                end
                                else
                                begin
                                    c_reg <= CMP_W'(sim_count_reg);
                                end
                                op_reg <= OP_SIM_Q;
                            end
                            OP_SIM_Q:
                            begin
                                if (f_sim_reg)
                                begin
                                    sim_count_reg  <= next_count(quo_w, c_reg);
                                    synch_done_reg <= 1'b0;
                                end
                                op_reg <= OP_RECV_T;
                            end
                            OP_RECV_T:
                            begin
                                c_reg      <= quo_w;
                                f_recv_reg <= (quo_w >= CMP_W'(recv_count_reg));
                                op_reg     <= OP_RECV_Q;
                            end
                            OP_RECV_Q:
                            begin
                                if (f_recv_reg)
                                    recv_count_reg <= next_count(quo_w, c_reg);
                                op_reg <= OP_SENSE_T;
                            end
                            OP_SENSE_T:
                            begin
                                c_reg       <= quo_w;
                                f_sense_reg <= (quo_w >= CMP_W'(sense_count_reg));
                                op_reg      <= OP_SENSE_Q;
                            end
                            OP_SENSE_Q:
                            begin
                                if (f_sense_reg)
                                    sense_count_reg <= next_count(quo_w, c_reg);
                                op_reg <= OP_VIS_T;
                            end
                            OP_VIS_T:
                            begin
                                c_reg     <= quo_w;
                                f_vis_reg <= (quo_w >= CMP_W'(visual_count_reg));
                                op_reg    <= OP_VIS_Q;
                            end
                            OP_VIS_Q:
                            begin
                                // Visual runs four times per send period.
                                if (f_vis_reg)
                                    visual_count_reg <= next_count(quo_w << 2, c_reg);
                                op_reg <= OP_SYNCH;
                            end
                            OP_SYNCH:
                            begin
                                if (!synch_done_reg && syn_ge &&
                                    quo_w >= CMP_W'(synch_prev))
                                begin
                                    f_synch_reg     <= 1'b1;
                                    synch_count_reg <= synch_count_reg + COUNT_BITS'(1);
                                    synch_done_reg  <= 1'b1;
                                end
                                op_reg <= OP_COACH_T;
                            end
                            OP_COACH_T:
                            begin
                                c_reg       <= quo_w;
                                f_coach_reg <= (quo_w >= CMP_W'(coach_count_reg));
                                op_reg      <= OP_COACH_Q;
                            end
                            OP_COACH_Q:
                            begin
                                if (f_coach_reg)
                                    coach_count_reg <= next_count(quo_w, c_reg);
                                state_reg <= S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH:
                begin
                    if (finish_load)
                    begin
                        if (t_reg >= TIME_W'(cfg.common_period))
                        begin
                            cycle_time_reg  <= '0;
                            synch_count_reg <= COUNT_BITS'(1);
                        end
                        else
                        begin
                            cycle_time_reg <= t_reg;
                        end
                        fire_recv_reg   <= f_recv_reg;
                        fire_sim_reg    <= f_sim_reg;
                        fire_sense_reg  <= f_sense_reg;
                        fire_visual_reg <= f_vis_reg;
                        fire_synch_reg  <= f_synch_reg;
                        fire_coach_reg  <= f_coach_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tick_ready  = (state_reg == S_IDLE);
    assign flags_valid = flags_valid_reg;
    assign fire_recv   = fire_recv_reg;
    assign fire_sim    = fire_sim_reg;
    assign fire_sense  = fire_sense_reg;
    assign fire_visual = fire_visual_reg;
    assign fire_synch  = fire_synch_reg;
    assign fire_coach  = fire_coach_reg;

    // The divider is only started when it is free, and only answers while waited on.
    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WAIT))
        else $error("divider result arrived outside the wait state");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_valid && tick_ready) |=> (state_reg == S_START && op_reg == OP_SIM_T))
        else $error("accepted tick did not start the division sequence");

    a_time_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        finish_load |=> (cycle_time_reg == '0 ||
                         cycle_time_reg < TIME_W'($past(cfg.common_period))))
        else $error("cycle time left at or beyond the common period");

    a_synch_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(finish_load) && fire_synch_reg) |-> synch_done_reg)
        else $error("synch visual reported without its done flag");

endmodule

`default_nettype wire
